/* rtl/core/pn2d_pkg.sv */
// Shared types, codes and a helper function for the 2D gradient noise pipeline.
// No dependencies.
package pn2d_pkg;

    localparam int PERM_SIZE = 256;
    localparam int PERM_AW   = 8;

    localparam logic [1:0] CMD_LOAD_PERM = 2'd0;
    localparam logic [1:0] CMD_LOAD_GRAD = 2'd1;
    localparam logic [1:0] CMD_EVAL      = 2'd2;

    localparam logic [1:0] CFG_COORD_STEP     = 2'd0;
    localparam logic [1:0] CFG_OUTPUT_SCALE   = 2'd1;
    localparam logic [1:0] CFG_GRADIENT_COUNT = 2'd2;

    typedef logic [PERM_AW-1:0] perm_t;
    typedef logic [15:0] frac_t;
    typedef logic [16:0] fade_t;
    typedef logic signed [15:0] comp_t;

    // One restoring step of an 8-bit remainder against a divisor of up to 256.
    function automatic perm_t mod_step(perm_t r, logic b, logic [8:0] d);
        logic [8:0] t;
        t = {r, b};
        if (t >= d) begin
            return perm_t'(t - d);
        end
        return t[7:0];
    endfunction

endpackage

/* rtl/core/perlin_noise_2d_pixel.sv */
// Per-pixel 2D gradient noise: twelve-stage pipeline, one request per cycle.
// Throughput is one request per clock, limited only by downstream stalls.
// Reset clears all valid bits and loads the default configuration; the tables keep
// their contents and must be loaded before use.
module perlin_noise_2d_pixel #(
    parameter int COORD_BITS    = 12,
    parameter int MAX_GRADIENTS = 256
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [16:0]             cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_cmd,
    input  logic [7:0]              s_index,
    input  logic [7:0]              s_perm_value,
    input  logic signed [15:0]      s_grad_x,
    input  logic signed [15:0]      s_grad_y,
    input  logic [COORD_BITS-1:0]   s_col,
    input  logic [COORD_BITS-1:0]   s_row,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [15:0]             m_noise_value,
    output logic signed [15:0]      m_raw_noise,
    output logic                    m_saturated
);
    import pn2d_pkg::*;

    localparam int PW = COORD_BITS + 17;
    localparam int XW = (PW > 24) ? PW : 24;
    localparam logic [8:0] MAX_G = 9'(MAX_GRADIENTS);

    logic [16:0] coord_step_reg;
    logic [15:0] output_scale_reg;
    logic [8:0]  gradient_count_reg;
    logic [8:0]  eff_count;

    logic [12:1] v_reg;
    logic [12:1] en;

    // Stage registers.
    logic [1:0]            cmd_reg [1:11];
    perm_t                 idx_reg [1:6];
    perm_t                 pv_reg  [1:3];
    comp_t                 gx_reg  [1:6];
    comp_t                 gy_reg  [1:6];
    logic [COORD_BITS-1:0] s1_col_reg, s1_row_reg;
    perm_t                 s2_xi_reg, s2_yi_reg, s3_yi_reg;
    frac_t                 xf_reg [2:7];
    frac_t                 yf_reg [2:7];
    fade_t                 u_reg [6:9];
    fade_t                 v_fade_reg [6:8];
    logic signed [33:0]    c_reg [4];
    logic signed [33:0]    left_reg, right_reg, n_reg;
    logic signed [51:0]    prod_reg;
    logic signed [15:0]    raw11_reg;
    logic [15:0]           nv_reg;
    logic signed [15:0]    raw_reg;
    logic                  sat_reg;

    // Combinational terms.
    logic [XW-1:0]         x_full, y_full;
    perm_t                 px0, px1;
    perm_t                 hash [4];
    perm_t                 hash_addr [4];
    perm_t                 g [4];
    logic [31:0]           grad [4];
    fade_t                 u5, v5;
    logic signed [33:0]    corner [4];
    logic signed [16:0]    dx [4];
    logic signed [16:0]    dy [4];
    logic signed [34:0]    left_next, right_next, n_next;
    logic signed [51:0]    prod_next;
    logic signed [17:0]    raw_wide;
    logic signed [15:0]    raw_next;

    // Configuration.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coord_step_reg     <= 17'd65536;
            output_scale_reg   <= 16'd256;
            gradient_count_reg <= 9'd8;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_COORD_STEP:     coord_step_reg     <= cfg_data;
                CFG_OUTPUT_SCALE:   output_scale_reg   <= cfg_data[15:0];
                CFG_GRADIENT_COUNT: gradient_count_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (gradient_count_reg == 9'd0) begin
            eff_count = 9'd1;
        end else if (gradient_count_reg > MAX_G) begin
            eff_count = MAX_G;
        end else begin
            eff_count = gradient_count_reg;
        end
    end

    // Stage enables: a stage loads when it is empty or the next one loads.
    assign en[12] = !v_reg[12] || m_ready;
    for (genvar k = 1; k < 12; k++) begin : g_en
        assign en[k] = !v_reg[k] || en[k+1];
    end
    assign s_ready = en[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[1]) begin
                v_reg[1] <= s_valid;
            end
            for (int k = 2; k < 12; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
            if (en[12]) begin
                v_reg[12] <= v_reg[11] && (cmd_reg[11] == CMD_EVAL);
            end
        end
    end

    // Stage 1 to 2: lattice coordinates.
    always_comb begin
        x_full = XW'(s1_col_reg) * XW'(coord_step_reg);
        y_full = XW'(s1_row_reg) * XW'(coord_step_reg);
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            cmd_reg[1] <= s_cmd;
            idx_reg[1] <= s_index;
            pv_reg[1]  <= s_perm_value;
            gx_reg[1]  <= s_grad_x;
            gy_reg[1]  <= s_grad_y;
            s1_col_reg <= s_col;
            s1_row_reg <= s_row;
        end
        if (en[2]) begin
            s2_xi_reg <= x_full[23:16];
            s2_yi_reg <= y_full[23:16];
            xf_reg[2] <= x_full[15:0];
            yf_reg[2] <= y_full[15:0];
        end
        if (en[3]) begin
            s3_yi_reg <= s2_yi_reg;
        end
        for (int k = 2; k <= 11; k++) begin
            if (en[k]) begin
                cmd_reg[k] <= cmd_reg[k-1];
            end
        end
        for (int k = 2; k <= 6; k++) begin
            if (en[k]) begin
                idx_reg[k] <= idx_reg[k-1];
                gx_reg[k]  <= gx_reg[k-1];
                gy_reg[k]  <= gy_reg[k-1];
            end
        end
        for (int k = 2; k <= 3; k++) begin
            if (en[k]) begin
                pv_reg[k] <= pv_reg[k-1];
            end
        end
        for (int k = 3; k <= 7; k++) begin
            if (en[k]) begin
                xf_reg[k] <= xf_reg[k-1];
                yf_reg[k] <= yf_reg[k-1];
            end
        end
    end

    // Fade curves, stages 3 to 5.
    pn2d_fade u_fade_x (.aclk(aclk), .en(en[5:3]), .t(xf_reg[2]), .fade(u5));
    pn2d_fade u_fade_y (.aclk(aclk), .en(en[5:3]), .t(yf_reg[2]), .fade(v5));

    // Row hashes, read into stage 3.
    pn2d_ram #(.WIDTH(8), .DEPTH(PERM_SIZE)) u_perm_x0 (
        .aclk(aclk), .en(en[3]), .we(v_reg[2] && cmd_reg[2] == CMD_LOAD_PERM),
        .waddr(idx_reg[2]), .wdata(pv_reg[2]), .raddr(s2_xi_reg), .rdata(px0)
    );
    pn2d_ram #(.WIDTH(8), .DEPTH(PERM_SIZE)) u_perm_x1 (
        .aclk(aclk), .en(en[3]), .we(v_reg[2] && cmd_reg[2] == CMD_LOAD_PERM),
        .waddr(idx_reg[2]), .wdata(pv_reg[2]), .raddr(s2_xi_reg + 8'd1), .rdata(px1)
    );

    // Corner hashes, read into stage 4.
    assign hash_addr[0] = px0 + s3_yi_reg;
    assign hash_addr[1] = px0 + s3_yi_reg + 8'd1;
    assign hash_addr[2] = px1 + s3_yi_reg;
    assign hash_addr[3] = px1 + s3_yi_reg + 8'd1;

    for (genvar c = 0; c < 4; c++) begin : g_corner
        pn2d_ram #(.WIDTH(8), .DEPTH(PERM_SIZE)) u_perm_c (
            .aclk(aclk), .en(en[4]), .we(v_reg[3] && cmd_reg[3] == CMD_LOAD_PERM),
            .waddr(idx_reg[3]), .wdata(pv_reg[3]), .raddr(hash_addr[c]), .rdata(hash[c])
        );
        pn2d_hmod u_hmod (
            .aclk(aclk), .en(en[6:5]), .hash(hash[c]), .divisor(eff_count), .rem(g[c])
        );
        pn2d_ram #(.WIDTH(32), .DEPTH(PERM_SIZE)) u_grad (
            .aclk(aclk), .en(en[7]), .we(v_reg[6] && cmd_reg[6] == CMD_LOAD_GRAD),
            .waddr(idx_reg[6]), .wdata({gx_reg[6], gy_reg[6]}), .raddr(g[c]),
            .rdata(grad[c])
        );
        assign dx[c]     = (c >= 2) ? $signed({1'b1, xf_reg[7]}) : $signed({1'b0, xf_reg[7]});
        assign dy[c]     = (c % 2 == 1) ? $signed({1'b1, yf_reg[7]})
                                        : $signed({1'b0, yf_reg[7]});
        assign corner[c] = 34'($signed(grad[c][31:16]) * dx[c])
                         + 34'($signed(grad[c][15:0]) * dy[c]);
    end

    // Interpolation and output mapping, stages 7 to 12.
    always_comb begin
        left_next  = 35'(c_reg[0]) + 35'((53'(35'(c_reg[1]) - 35'(c_reg[0]))
                   * 53'($signed({1'b0, v_fade_reg[8]}))) >>> 16);
        right_next = 35'(c_reg[2]) + 35'((53'(35'(c_reg[3]) - 35'(c_reg[2]))
                   * 53'($signed({1'b0, v_fade_reg[8]}))) >>> 16);
        n_next     = 35'(left_reg) + 35'((53'(35'(right_reg) - 35'(left_reg))
                   * 53'($signed({1'b0, u_reg[9]}))) >>> 16);
        prod_next  = 52'(35'(n_reg) + 35'(36'sd1073741824))
                   * 52'($signed({1'b0, output_scale_reg}));
        raw_wide   = 18'(n_reg >>> 16);
        if (raw_wide > 18'sd32767) begin
            raw_next = 16'sh7FFF;
        end else if (raw_wide < -18'sd32768) begin
            raw_next = -16'sh8000;
        end else begin
            raw_next = raw_wide[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            u_reg[6]      <= u5;
            v_fade_reg[6] <= v5;
        end
        if (en[7]) begin
            u_reg[7]      <= u_reg[6];
            v_fade_reg[7] <= v_fade_reg[6];
        end
        if (en[8]) begin
            u_reg[8]      <= u_reg[7];
            v_fade_reg[8] <= v_fade_reg[7];
            for (int c = 0; c < 4; c++) begin
                c_reg[c] <= corner[c];
            end
        end
        if (en[9]) begin
            u_reg[9]  <= u_reg[8];
            left_reg  <= left_next[33:0];
            right_reg <= right_next[33:0];
        end
        if (en[10]) begin
            n_reg <= n_next[33:0];
        end
        if (en[11]) begin
            prod_reg  <= prod_next;
            raw11_reg <= raw_next;
        end
        if (en[12]) begin
            raw_reg <= raw11_reg;
            if (prod_reg[51]) begin
                nv_reg  <= 16'd0;
                sat_reg <= 1'b1;
            end else if (|prod_reg[50:47]) begin
                nv_reg  <= 16'hFFFF;
                sat_reg <= 1'b1;
            end else begin
                nv_reg  <= prod_reg[46:31];
                sat_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = v_reg[12];
    assign m_noise_value = nv_reg;
    assign m_raw_noise   = raw_reg;
    assign m_saturated   = sat_reg;

    // The input side stalls only when the first stage holds a request.
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> v_reg[1])
        else $error("input stalled with an empty first stage");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        eff_count != 9'd0 && eff_count <= MAX_G)
        else $error("gradient modulus out of range");

    a_grad_index: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[6] && cmd_reg[6] == CMD_EVAL |->
            {1'b0, g[0]} < eff_count && {1'b0, g[1]} < eff_count &&
            {1'b0, g[2]} < eff_count && {1'b0, g[3]} < eff_count)
        else $error("gradient index not below the modulus");

    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |-> m_noise_value == 16'd0 || m_noise_value == 16'hFFFF)
        else $error("saturated result not at a range limit");

endmodule

/* rtl/core/pn2d_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pn2d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem_reg[waddr] <= wdata;
            end
            rdata <= mem_reg[raddr];
        end
    end
endmodule

/* rtl/core/pn2d_fade.sv */
// Three-stage quintic fade curve 6t^5 - 15t^4 + 10t^3 on a Q0.16 fraction.
// Depends on pn2d_pkg.
module pn2d_fade (
    input  logic            aclk,
    input  logic [2:0]      en,
    input  pn2d_pkg::frac_t t,
    output pn2d_pkg::fade_t fade
);
    import pn2d_pkg::*;

    frac_t       t_a_reg;
    frac_t       t2_a_reg;
    frac_t       t3_b_reg;
    logic [19:0] k_b_reg;
    fade_t       fade_c_reg;
    logic [31:0] sq;
    logic [31:0] cube;
    logic [20:0] k_next;
    logic [35:0] prod;

    always_comb begin
        sq     = 32'(t) * 32'(t);
        cube   = 32'(t2_a_reg) * 32'(t_a_reg);
        k_next = 21'(6) * 21'(t2_a_reg) + 21'(655360) - 21'(15) * 21'(t_a_reg);
        prod   = 36'(t3_b_reg) * 36'(k_b_reg);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            t_a_reg  <= t;
            t2_a_reg <= sq[31:16];
        end
        if (en[1]) begin
            t3_b_reg <= cube[31:16];
            k_b_reg  <= k_next[19:0];
        end
        if (en[2]) begin
            fade_c_reg <= prod[32:16];
        end
    end

    assign fade = fade_c_reg;
endmodule

/* rtl/core/pn2d_hmod.sv */
// Two-stage restoring remainder of an 8-bit hash by the gradient count.
// Depends on pn2d_pkg.
module pn2d_hmod (
    input  logic            aclk,
    input  logic [1:0]      en,
    input  pn2d_pkg::perm_t hash,
    input  logic [8:0]      divisor,
    output pn2d_pkg::perm_t rem
);
    import pn2d_pkg::*;

    perm_t       r_a_reg;
    logic [3:0]  low_a_reg;
    perm_t       r_b_reg;
    perm_t       ra;
    perm_t       rb;

    always_comb begin
        ra = '0;
        for (int i = 7; i >= 4; i--) begin
            ra = mod_step(ra, hash[i], divisor);
        end
        rb = r_a_reg;
        for (int i = 3; i >= 0; i--) begin
            rb = mod_step(rb, low_a_reg[i], divisor);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            r_a_reg   <= ra;
            low_a_reg <= hash[3:0];
        end
        if (en[1]) begin
            r_b_reg <= rb;
        end
    end

    assign rem = r_b_reg;
endmodule
